[hw/rtl/keyboard_latch_with_paste_fifo_defines.svh]
// Assertion macros shared by the keyboard latch RTL.
// Used by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef KEYBOARD_LATCH_WITH_PASTE_FIFO_DEFINES_SVH
`define KEYBOARD_LATCH_WITH_PASTE_FIFO_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define KLPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define KLPF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define KLPF_ASSERT(label, prop, msg)
`define KLPF_NEVER(label, cond, msg)
`endif
`endif

[hw/rtl/klpf_pkg.sv]
// Shared types and constants for the keyboard latch with paste queue.
// No dependencies; used by klpf_text_filter, klpf_queue and the top level.
package klpf_pkg;

	// Queue geometry
	localparam int QDEPTH = 1024;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Limit on bytes held by latch plus queue for paste traffic
	localparam int MAX_IN_FLIGHT = 1024;
	localparam int IFW = $clog2(((MAX_IN_FLIGHT > QDEPTH) ? MAX_IN_FLIGHT : QDEPTH) + 2);

	// Character codes
	localparam logic [7:0] CHAR_CR_RAW = 8'h0D;
	localparam logic [7:0] CHAR_LF_RAW = 8'h0A;
	localparam logic [6:0] CHAR_CR     = 7'h0D;
	localparam logic [6:0] CHAR_TAB    = 7'h09;
	localparam logic [6:0] CHAR_SPACE  = 7'h20;
	localparam logic [6:0] CASE_OFFSET = 7'h20;
	localparam logic [6:0] LOWER_A     = 7'h61;
	localparam logic [6:0] LOWER_Z     = 7'h7A;

	typedef enum logic [1:0] {
		ACT_LIVE  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_TEXT  = 2'd2,
		ACT_RAW   = 2'd3
	} action_t;

	// Input item
	typedef struct packed {
		action_t     action;
		logic [7:0]  key_byte;
		logic        first_of_paste;
	} req_t;

	// Result item
	typedef struct packed {
		logic [6:0]     latch_key;
		logic           strobe_res;
		logic           accepted;
		logic           overflow;
		logic [QCW-1:0] queue_count;
	} rsp_t;

	// Text filter verdict
	typedef struct packed {
		logic       keep;
		logic [6:0] ch;
		logic       prev_cr;
	} filt_t;

	// Queue control and status
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [6:0] wr_data;
	} qctl_t;

	typedef struct packed {
		logic [QCW-1:0] fill;
		logic [6:0]     head_data;
	} qsts_t;

endpackage

[hw/rtl/keyboard_latch_with_paste_fifo.sv]
// Keyboard latch with strobe and a paste queue: top level.
// Depends on klpf_pkg, klpf_text_filter, klpf_queue and the defines header.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one action per item: live key,
//   strobe clear, text paste byte or raw paste byte. Every item yields exactly
//   one result on rsp (rsp_valid/rsp_stall/rsp): latch contents, strobe,
//   accepted/overflow flags and the queue fill after that item.
//   cfg (cfg_valid/cfg_ready/cfg_data) writes fold_to_upper; always ready.
// Timing:
//   One item per cycle while req_stall is low. The latch, strobe and queue update
//   in the accept cycle; the result is registered in the result register (or the
//   skid register while rsp waits) and shows on rsp from there. The queue head
//   is prefetched from the RAM's registered read so a strobe clear promotes it without waiting on the read port.
// Stall:
//   A two-deep output (result register plus skid register) lets one more item
//   in while a result waits; req_stall rises when the skid register is full.
// Reset:
//   Latch, strobe, CR tracking and queue pointers clear; fold_to_upper is set.
//   Queue RAM contents are not cleared and need no clearing pass.
`include "keyboard_latch_with_paste_fifo_defines.svh"
module keyboard_latch_with_paste_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  klpf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output klpf_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);

	localparam int QCW = klpf_pkg::QCW;
	localparam int IFW = klpf_pkg::IFW;

	logic           fold_q;
	logic [6:0]     latch_q;
	logic           strobe_q;
	logic           prev_cr_q;
	logic           accept;
	klpf_pkg::qctl_t qctl;
	klpf_pkg::qsts_t qsts;
	klpf_pkg::filt_t verdict;
	logic           q_empty;
	logic           q_full;
	logic [IFW-1:0] in_flight;
	logic           room;
	logic           prev_cr_eff;
	logic [6:0]     latch_nxt;
	logic           strobe_nxt;
	logic           prev_cr_nxt;
	logic           acc;
	logic           ovf;
	logic           place;
	logic [6:0]     place_ch;
	klpf_pkg::rsp_t rsp_new;
	klpf_pkg::rsp_t out_q;
	klpf_pkg::rsp_t skid_q;
	logic           out_valid_q;
	logic           skid_valid_q;
	logic           out_free;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && !req_stall;
	assign req_stall = skid_valid_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			fold_q <= cfg_data;
		end
	end

	assign prev_cr_eff = req.first_of_paste ? 1'b0 : prev_cr_q;

	klpf_text_filter u_filter (
		.key_byte (req.key_byte),
		.prev_cr  (prev_cr_eff),
		.fold     (fold_q),
		.verdict  (verdict)
	);

	// Paste admission: in-flight limit and queue depth
	assign q_empty   = (qsts.fill == '0);
	assign q_full    = (qsts.fill == QCW'(klpf_pkg::QDEPTH));
	assign in_flight = IFW'(qsts.fill) + IFW'(strobe_q);
	assign room      = (in_flight < IFW'(klpf_pkg::MAX_IN_FLIGHT))
		&& !((strobe_q || !q_empty) && q_full);

	// Per-action decision
	always_comb begin
		latch_nxt    = latch_q;
		strobe_nxt   = strobe_q;
		prev_cr_nxt  = prev_cr_q;
		acc          = 1'b0;
		ovf          = 1'b0;
		place        = 1'b0;
		place_ch     = req.key_byte[6:0];
		qctl.push    = 1'b0;
		qctl.pop     = 1'b0;
		qctl.wr_data = req.key_byte[6:0];
		case (req.action)
			klpf_pkg::ACT_LIVE: begin
				if (q_empty) begin
					latch_nxt  = req.key_byte[6:0];
					strobe_nxt = 1'b1;
					acc        = 1'b1;
				end else if (q_full) begin
					ovf = 1'b1;
				end else begin
					qctl.push = 1'b1;
					acc       = 1'b1;
				end
			end
			klpf_pkg::ACT_CLEAR: begin
				strobe_nxt = 1'b0;
				if (!q_empty) begin
					latch_nxt  = qsts.head_data;
					qctl.pop   = 1'b1;
					strobe_nxt = 1'b1;
				end
			end
			klpf_pkg::ACT_TEXT: begin
				prev_cr_nxt = prev_cr_eff;
				if (room) begin
					prev_cr_nxt = verdict.prev_cr;
					place       = verdict.keep;
					place_ch    = verdict.ch;
				end
			end
			klpf_pkg::ACT_RAW: begin
				place = room;
			end
			default: begin
				place = 1'b0;
			end
		endcase
		// Paste byte goes to an idle latch, else behind the queue if it has space
		if (place) begin
			if (!strobe_q && q_empty) begin
				latch_nxt  = place_ch;
				strobe_nxt = 1'b1;
				acc        = 1'b1;
			end else if (!q_full) begin
				qctl.push    = 1'b1;
				qctl.wr_data = place_ch;
				acc          = 1'b1;
			end
		end
		if (!accept) begin
			qctl.push = 1'b0;
			qctl.pop  = 1'b0;
		end
	end

	klpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (qctl),
		.sts    (qsts)
	);

	// Latch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q   <= '0;
			strobe_q  <= 1'b0;
			prev_cr_q <= 1'b0;
		end else if (accept) begin
			latch_q   <= latch_nxt;
			strobe_q  <= strobe_nxt;
			prev_cr_q <= prev_cr_nxt;
		end
	end

	// Result of this item
	always_comb begin
		rsp_new.latch_key  = latch_nxt;
		rsp_new.strobe_res = strobe_nxt;
		rsp_new.accepted   = acc;
		rsp_new.overflow   = ovf;
		rsp_new.queue_count = qsts.fill + QCW'(qctl.push) - QCW'(qctl.pop);
	end

	// Output register plus skid register
	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : rsp_new;
		end else if (accept) begin
			skid_q <= rsp_new;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`KLPF_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid holds item ahead of output")
	`KLPF_NEVER(a_queue_without_strobe, qsts.fill != '0 && !strobe_q, "queued bytes with strobe low")
	`KLPF_NEVER(a_ovf_and_acc, out_valid_q && out_q.overflow && out_q.accepted, "overflow on taken key")
	`KLPF_ASSERT(a_ovf_only_live, accept && rsp_new.overflow |-> req.action == klpf_pkg::ACT_LIVE, "overflow on non-live item")

endmodule

[hw/rtl/klpf_text_filter.sv]
// Normalizes one text-paste byte: line endings, high bit, controls, case fold.
// Depends on klpf_pkg.
module klpf_text_filter (
	input  logic [7:0]     key_byte,
	input  logic           prev_cr,
	input  logic           fold,
	output klpf_pkg::filt_t verdict
);

	logic [7:0] line_b;
	logic       lf_keep;
	logic       cr_now;
	logic [6:0] masked;

	// CR, LF and CRLF collapse to one CR
	always_comb begin
		line_b  = key_byte;
		lf_keep = 1'b1;
		cr_now  = 1'b0;
		if (key_byte == klpf_pkg::CHAR_CR_RAW) begin
			cr_now = 1'b1;
		end else if (key_byte == klpf_pkg::CHAR_LF_RAW) begin
			lf_keep = !prev_cr;
			line_b  = klpf_pkg::CHAR_CR_RAW;
		end
	end

	assign masked = line_b[6:0];

	// Drop codes below space other than CR and TAB, then fold lower case
	always_comb begin
		verdict.prev_cr = cr_now;
		verdict.keep    = lf_keep;
		verdict.ch      = masked;
		if (masked < klpf_pkg::CHAR_SPACE && masked != klpf_pkg::CHAR_CR
				&& masked != klpf_pkg::CHAR_TAB) begin
			verdict.keep = 1'b0;
		end
		if (fold && (masked inside {[klpf_pkg::LOWER_A:klpf_pkg::LOWER_Z]})) begin
			verdict.ch = masked - klpf_pkg::CASE_OFFSET;
		end
	end

endmodule

[hw/rtl/klpf_queue.sv]
// Paste queue: one synchronous RAM with head/tail/fill and a head-entry prefetch.
// Depends on klpf_pkg and keyboard_latch_with_paste_fifo_defines.svh.
`include "keyboard_latch_with_paste_fifo_defines.svh"
module klpf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  klpf_pkg::qctl_t ctl,
	output klpf_pkg::qsts_t sts
);

	localparam int QAW = klpf_pkg::QAW;
	localparam int QCW = klpf_pkg::QCW;

	logic [6:0]     mem [klpf_pkg::QDEPTH];
	logic [QAW-1:0] head_q;
	logic [QAW-1:0] tail_q;
	logic [QCW-1:0] fill_q;
	logic [QAW-1:0] head_nxt;
	logic [6:0]     rd_raw_q;
	logic [6:0]     fwd_data_q;
	logic           fwd_sel_q;
	logic           fwd_hit;

	// Address the entry that will be head after this cycle
	assign head_nxt = ctl.pop ? head_q + QAW'(1) : head_q;
	// A push into the slot being prefetched bypasses the RAM
	assign fwd_hit  = ctl.push && (tail_q == head_nxt);

	// RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= ctl.wr_data;
		end
		rd_raw_q   <= mem[head_nxt];
		fwd_data_q <= ctl.wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			fwd_sel_q <= 1'b0;
		end else begin
			head_q    <= head_nxt;
			fwd_sel_q <= fwd_hit;
			if (ctl.push) begin
				tail_q <= tail_q + QAW'(1);
			end
			if (ctl.push && !ctl.pop) begin
				fill_q <= fill_q + QCW'(1);
			end else if (ctl.pop && !ctl.push) begin
				fill_q <= fill_q - QCW'(1);
			end
		end
	end

	assign sts.fill      = fill_q;
	assign sts.head_data = fwd_sel_q ? fwd_data_q : rd_raw_q;

	`KLPF_NEVER(a_no_push_full, ctl.push && fill_q == QCW'(klpf_pkg::QDEPTH), "push into full queue")
	`KLPF_NEVER(a_no_pop_empty, ctl.pop && fill_q == '0, "pop from empty queue")
	`KLPF_ASSERT(a_empty_ptrs, fill_q == '0 |-> head_q == tail_q, "empty queue with split pointers")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for keyboard_latch_with_paste_fifo: a directed table, then random
// paste/key traffic against a cycle-free predictor of the latch, strobe and paste queue.
// Depends on klpf_pkg and the keyboard_latch_with_paste_fifo RTL.
module tb_top;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int QDEPTH        = klpf_pkg::QDEPTH;
	localparam int QAW           = klpf_pkg::QAW;
	localparam int QCW           = klpf_pkg::QCW;
	localparam int MAX_IN_FLIGHT = klpf_pkg::MAX_IN_FLIGHT;
	localparam int EXP_DEPTH     = 16;
	localparam int DIR_DEPTH     = 32;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	klpf_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	klpf_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	keyboard_latch_with_paste_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block state, starting from its reset values
	bit             shadow_fold    = 1'b1;
	logic [6:0]     shadow_latch   = '0;
	bit             shadow_strobe  = 1'b0;
	bit             shadow_prev_cr = 1'b0;
	logic [6:0]     shadow_store [QDEPTH];
	logic [QAW-1:0] shadow_head    = '0;
	logic [QAW-1:0] shadow_tail    = '0;
	int             shadow_fill    = 0;

	// Results still owed by the block, oldest first (ring of expected items)
	klpf_pkg::rsp_t exp_rsp [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;

	int mismatch_count = 0;
	int items_sent     = 0;
	int burst_left     = 0;
	int idle_gap       = 0;
	int cycle_count    = 0;
	int stall_mode     = 0;

	// Directed table
	typedef struct {
		klpf_pkg::req_t stim;
		bit             chk;
		klpf_pkg::rsp_t want;
	} dir_row_t;
	dir_row_t dir_rows [DIR_DEPTH];
	int       dir_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor
	function automatic void store_push(input logic [6:0] ch);
		shadow_store[shadow_tail] = ch;
		shadow_tail = shadow_tail + QAW'(1);
		shadow_fill++;
	endfunction

	function automatic bit paste_has_room();
		int held;
		held = shadow_fill + (shadow_strobe ? 1 : 0);
		if (held >= MAX_IN_FLIGHT)
			return 1'b0;
		if ((shadow_strobe || shadow_fill != 0) && shadow_fill >= QDEPTH)
			return 1'b0;
		return 1'b1;
	endfunction

	// Paste byte goes straight to an empty latch, else behind the queue if it has space
	function automatic bit paste_put(input logic [6:0] ch);
		if (!shadow_strobe && shadow_fill == 0) begin
			shadow_latch = ch;
			shadow_strobe = 1'b1;
			return 1'b1;
		end
		if (shadow_fill >= QDEPTH)
			return 1'b0;
		store_push(ch);
		return 1'b1;
	endfunction

	function automatic klpf_pkg::rsp_t predict_latch_rsp(input klpf_pkg::req_t it);
		klpf_pkg::rsp_t r;
		logic [7:0]     b;
		logic [6:0]     ch;
		bit             keep;
		bit             acc;
		bit             ovf;
		acc = 1'b0;
		ovf = 1'b0;
		case (it.action)
			klpf_pkg::ACT_LIVE: begin
				if (shadow_fill == 0) begin
					shadow_latch = it.key_byte[6:0];
					shadow_strobe = 1'b1;
					acc = 1'b1;
				end else if (shadow_fill >= QDEPTH) begin
					ovf = 1'b1;
				end else begin
					store_push(it.key_byte[6:0]);
					acc = 1'b1;
				end
			end
			klpf_pkg::ACT_CLEAR: begin
				shadow_strobe = 1'b0;
				if (shadow_fill != 0) begin
					shadow_latch = shadow_store[shadow_head];
					shadow_head = shadow_head + QAW'(1);
					shadow_fill--;
					shadow_strobe = 1'b1;
				end
			end
			klpf_pkg::ACT_TEXT: begin
				if (it.first_of_paste)
					shadow_prev_cr = 1'b0;
				if (paste_has_room()) begin
					b = it.key_byte;
					keep = 1'b1;
					// CR, LF and CRLF all collapse to one CR
					if (b == klpf_pkg::CHAR_CR_RAW) begin
						shadow_prev_cr = 1'b1;
					end else if (b == klpf_pkg::CHAR_LF_RAW) begin
						if (shadow_prev_cr)
							keep = 1'b0;
						b = klpf_pkg::CHAR_CR_RAW;
						shadow_prev_cr = 1'b0;
					end else begin
						shadow_prev_cr = 1'b0;
					end
					ch = b[6:0];
					if (keep && ch < klpf_pkg::CHAR_SPACE && ch != klpf_pkg::CHAR_CR
							&& ch != klpf_pkg::CHAR_TAB)
						keep = 1'b0;
					if (keep) begin
						if (shadow_fold && ch >= klpf_pkg::LOWER_A && ch <= klpf_pkg::LOWER_Z)
							ch = ch - klpf_pkg::CASE_OFFSET;
						acc = paste_put(ch);
					end
				end
			end
			default: begin
				if (paste_has_room())
					acc = paste_put(it.key_byte[6:0]);
			end
		endcase
		r.latch_key   = shadow_latch;
		r.strobe_res  = shadow_strobe;
		r.accepted    = acc;
		r.overflow    = ovf;
		r.queue_count = shadow_fill[QCW-1:0];
		return r;
	endfunction

	// Append one expected result
	function automatic void owe_rsp(input klpf_pkg::rsp_t r);
		exp_rsp[exp_wr[3:0]] = r;
		exp_wr++;
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		klpf_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (exp_wr == exp_rd) begin
				report_mismatch("result with nothing pending", int'(rsp), 0);
			end else begin
				want = exp_rsp[exp_rd[3:0]];
				exp_rd++;
				if (rsp.latch_key !== want.latch_key)
					report_mismatch("latch_key", int'(rsp.latch_key), int'(want.latch_key));
				if (rsp.strobe_res !== want.strobe_res)
					report_mismatch("strobe_res", int'(rsp.strobe_res), int'(want.strobe_res));
				if (rsp.accepted !== want.accepted)
					report_mismatch("accepted", int'(rsp.accepted), int'(want.accepted));
				if (rsp.overflow !== want.overflow)
					report_mismatch("overflow", int'(rsp.overflow), int'(want.overflow));
				if (rsp.queue_count !== want.queue_count)
					report_mismatch("queue_count", int'(rsp.queue_count),
						int'(want.queue_count));
			end
		end
	end

	// Receiver stall pattern and run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 128 == 0)
			stall_mode = $urandom_range(0, 4);
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 99) < 30);
			2: rsp_stall <= ($urandom_range(0, 99) < 75);
			3: rsp_stall <= (cycle_count % 8 < 3);
			default: rsp_stall <= (cycle_count % 64 < 40);
		endcase
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------- driving
	// Offer one item in bursts with random gaps; returns at the accepting edge
	task automatic drive_item(input klpf_pkg::req_t it);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
			                                         : $urandom_range(1, 12);
			idle_gap = $urandom_range(0, 5);
			if (idle_gap != 0) begin
				req_valid <= 1'b0;
				repeat (idle_gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	task automatic send(input klpf_pkg::action_t a, input logic [7:0] b, input bit f);
		klpf_pkg::req_t it;
		it.action = a;
		it.key_byte = b;
		it.first_of_paste = f;
		drive_item(it);
		owe_rsp(predict_latch_rsp(it));
	endtask

	// Hold the sender until every owed result is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_fold(input bit v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		shadow_fold = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		case ($urandom_range(0, 11))
			0: b = klpf_pkg::CHAR_CR_RAW;
			1: b = klpf_pkg::CHAR_LF_RAW;
			2, 3: b = 8'($urandom_range(8'h61, 8'h7A));
			4: b = 8'($urandom_range(8'h41, 8'h5A));
			5, 6: b = 8'($urandom_range(8'h20, 8'h7E));
			7: b = 8'($urandom_range(0, 31));
			8: b = 8'($urandom_range(128, 255));
			9: b = 8'h09;
			10: begin
				case ($urandom_range(0, 4))
					0: b = 8'h60;
					1: b = 8'h7B;
					2: b = 8'h7F;
					3: b = 8'h20;
					default: b = 8'h1F;
				endcase
			end
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// One text paste call: first byte marked, CRLF pairs likely after a CR
	task automatic send_text_run(input int len);
		logic [7:0] b;
		bit         last_cr;
		last_cr = 1'b0;
		for (int i = 0; i < len; i++) begin
			if (last_cr && $urandom_range(0, 1) == 1)
				b = klpf_pkg::CHAR_LF_RAW;
			else
				b = pick_text_byte();
			send(klpf_pkg::ACT_TEXT, b, (i == 0));
			last_cr = (b == klpf_pkg::CHAR_CR_RAW);
		end
	endtask

	task automatic run_mix(input int n, input int clear_pct);
		int target;
		int sub;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < clear_pct) begin
				send(klpf_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				sub = $urandom_range(0, 99);
				if (sub < 25)
					send(klpf_pkg::ACT_LIVE, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				else if (sub < 65)
					send_text_run($urandom_range(1, 10));
				else if (sub < 85)
					for (int i = $urandom_range(1, 6); i > 0; i--)
						send(klpf_pkg::ACT_RAW, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
				else
					send(klpf_pkg::action_t'(2'($urandom_range(0, 3))),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// No clears: fill latch and queue to the limits, then keep pushing
	task automatic run_flood();
		int extra;
		int pick;
		extra = 0;
		while (extra < 40) begin
			if (shadow_fill >= QDEPTH)
				extra++;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send(klpf_pkg::ACT_RAW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else if (pick < 65)
				send(klpf_pkg::ACT_TEXT, pick_text_byte(), ($urandom_range(0, 9) == 0));
			else
				send(klpf_pkg::ACT_LIVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic add_row(input klpf_pkg::action_t a, input logic [7:0] b, input bit f,
	                       input bit chk, input logic [6:0] lk, input bit st, input bit ac,
	                       input bit ov, input int cnt);
		dir_row_t row;
		row.stim.action = a;
		row.stim.key_byte = b;
		row.stim.first_of_paste = f;
		row.chk = chk;
		row.want.latch_key = lk;
		row.want.strobe_res = st;
		row.want.accepted = ac;
		row.want.overflow = ov;
		row.want.queue_count = cnt[QCW-1:0];
		dir_rows[dir_count] = row;
		dir_count++;
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		klpf_pkg::rsp_t r;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, fold_to_upper at its reset value
		add_row(klpf_pkg::ACT_CLEAR, 8'h00, 1'b0, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 0);  // clear, empty
		add_row(klpf_pkg::ACT_LIVE,  8'hFF, 1'b0, 1'b1, 7'h7F, 1'b1, 1'b1, 1'b0, 0);  // high bit off
		add_row(klpf_pkg::ACT_LIVE,  8'h00, 1'b1, 1'b1, 7'h00, 1'b1, 1'b1, 1'b0, 0);  // newest wins
		add_row(klpf_pkg::ACT_CLEAR, 8'hFF, 1'b1, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h61, 1'b1, 1'b1, 7'h41, 1'b1, 1'b1, 1'b0, 0);  // folded
		add_row(klpf_pkg::ACT_TEXT,  8'h0D, 1'b0, 1'b1, 7'h41, 1'b1, 1'b1, 1'b0, 1);  // CR queued
		add_row(klpf_pkg::ACT_TEXT,  8'h0A, 1'b0, 1'b1, 7'h41, 1'b1, 1'b0, 1'b0, 1);  // LF dropped
		add_row(klpf_pkg::ACT_TEXT,  8'h0A, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);     // lone LF
		add_row(klpf_pkg::ACT_TEXT,  8'h01, 1'b0, 1'b1, 7'h41, 1'b1, 1'b0, 1'b0, 2);  // control
		add_row(klpf_pkg::ACT_TEXT,  8'h09, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h8D, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'hFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_RAW,   8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);     // controls kept
		add_row(klpf_pkg::ACT_RAW,   8'hE1, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);     // not folded
		add_row(klpf_pkg::ACT_LIVE,  8'h5A, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);     // appended
		add_row(klpf_pkg::ACT_TEXT,  8'h0D, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h0A, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);     // CR forgotten
		add_row(klpf_pkg::ACT_TEXT,  8'h60, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h7B, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h7A, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h20, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_TEXT,  8'h1F, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_CLEAR, 8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);     // head promoted
		add_row(klpf_pkg::ACT_CLEAR, 8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
		add_row(klpf_pkg::ACT_LIVE,  8'h80, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);

		for (int i = 0; i < dir_count; i++) begin
			drive_item(dir_rows[i].stim);
			r = predict_latch_rsp(dir_rows[i].stim);
			owe_rsp(dir_rows[i].chk ? dir_rows[i].want : r);
		end

		// Random phases, each under its own fold setting
		write_fold(1'b0);
		run_mix(15, 30);
		write_fold(1'b1);
		run_mix(15, 30);
		wait_drained();
		run_flood();
		write_fold(1'b0);
		run_mix(20, 55);
		write_fold(1'b1);
		run_mix(10, 40);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
